### sv/rvsx_pkg.sv
// Shared types and constants of the RV32I subset executor.
package rvsx_pkg;

    localparam int XLEN = 32;

    localparam logic [6:0] OP_REG    = 7'h33;
    localparam logic [6:0] OP_IMM    = 7'h13;
    localparam logic [6:0] OP_LOAD   = 7'h03;
    localparam logic [6:0] OP_STORE  = 7'h23;
    localparam logic [6:0] OP_BRANCH = 7'h63;
    localparam logic [6:0] OP_JAL    = 7'h6F;
    localparam logic [6:0] OP_SYSTEM = 7'h73;

    localparam logic [6:0] F7_ADD  = 7'h00;
    localparam logic [6:0] F7_SUB  = 7'h20;
    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_WORD = 3'd2;
    localparam logic [2:0] F3_BEQ  = 3'd0;

    localparam logic [XLEN-1:0] ECALL_WORD = 32'h0000_0073;

    localparam logic ITEM_EXEC    = 1'b0;
    localparam logic ITEM_PRELOAD = 1'b1;

    localparam logic [4:0] REG_ZERO = 5'd0;
    localparam logic [4:0] REG_SP   = 5'd2;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_ECALL     = 3'd1,
        ST_UNKNOWN   = 3'd2,
        ST_VIOLATION = 3'd3,
        ST_HALTED    = 3'd4
    } status_t;

    typedef struct packed {
        logic            rd;
        logic            wr;
        logic [XLEN-1:0] addr;
        logic [XLEN-1:0] wdata;
    } mem_req_t;

    typedef struct packed {
        logic            en;
        logic [4:0]      idx;
        logic [XLEN-1:0] data;
    } rf_write_t;

    typedef struct packed {
        status_t         status;
        logic [XLEN-1:0] next_pc;
        logic            reg_we;
        logic [4:0]      reg_idx;
        logic [XLEN-1:0] reg_value;
        logic            halt;
        mem_req_t        mem;
    } exec_res_t;

endpackage

### sv/rvsx_regfile.sv
// Register file: two registered read ports, one write port, per-entry valid bits for reset.
module rvsx_regfile
    import rvsx_pkg::*;
#(
    parameter int MEM_BYTES = 65536
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            rd_en,
    input  logic [4:0]      ra1,
    input  logic [4:0]      ra2,
    input  rf_write_t       wr,
    output logic [XLEN-1:0] rd1,
    output logic [XLEN-1:0] rd2
);

    localparam logic [XLEN-1:0] SP_RESET = XLEN'(MEM_BYTES - 4);

    logic [XLEN-1:0] regs [32];
    logic [31:0]     valid_reg;
    logic [XLEN-1:0] q1_reg;
    logic [XLEN-1:0] q2_reg;
    logic [XLEN-1:0] byp_data_reg;
    logic            byp1_reg;
    logic            byp2_reg;
    logic            val1_reg;
    logic            val2_reg;
    logic            sp1_reg;
    logic            sp2_reg;
    logic            wr_ok;

    assign wr_ok = wr.en && (wr.idx != REG_ZERO);

    always_ff @(posedge clk)
    begin
        if (wr_ok)
        begin
            regs[wr.idx] <= wr.data;
        end
        if (rd_en)
        begin
            q1_reg <= regs[ra1];
            q2_reg <= regs[ra2];
            byp_data_reg <= wr.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            byp1_reg  <= 1'b0;
            byp2_reg  <= 1'b0;
            val1_reg  <= 1'b0;
            val2_reg  <= 1'b0;
            sp1_reg   <= 1'b0;
            sp2_reg   <= 1'b0;
        end
        else
        begin
            if (wr_ok)
            begin
                valid_reg[wr.idx] <= 1'b1;
            end
            if (rd_en)
            begin
                // write-first: an item retiring in the same cycle forwards its result
                byp1_reg <= wr_ok && (wr.idx == ra1);
                byp2_reg <= wr_ok && (wr.idx == ra2);
                val1_reg <= valid_reg[ra1];
                val2_reg <= valid_reg[ra2];
                sp1_reg  <= (ra1 == REG_SP);
                sp2_reg  <= (ra2 == REG_SP);
            end
        end
    end

    assign rd1 = byp1_reg ? byp_data_reg :
                 val1_reg ? q1_reg :
                 sp1_reg  ? SP_RESET : '0;
    assign rd2 = byp2_reg ? byp_data_reg :
                 val2_reg ? q2_reg :
                 sp2_reg  ? SP_RESET : '0;

endmodule

### sv/rvsx_dmem.sv
// Byte-addressed data memory in four byte lanes with unaligned word access and reset sweep.
module rvsx_dmem
    import rvsx_pkg::*;
#(
    parameter int MEM_BYTES = 65536
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  mem_req_t        req,
    output logic [XLEN-1:0] rdata,
    output logic            busy
);

    localparam int ROWS = (MEM_BYTES + 3) / 4;
    localparam int RW   = $clog2(ROWS);
    localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);

    logic [RW-1:0] clr_cnt_reg;
    logic          clr_busy_reg;
    logic [1:0]    off;
    logic [1:0]    off_reg;
    logic [RW-1:0] row_base;
    logic [RW-1:0] rows [4];
    logic [7:0]    wbytes [4];
    logic [7:0]    lane_q [4];
    logic          wen;

    assign off      = req.addr[1:0];
    assign row_base = req.addr[RW+1:2];
    assign wen      = clr_busy_reg || req.wr;
    assign busy     = clr_busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg  <= '0;
            clr_busy_reg <= 1'b1;
        end
        else if (clr_busy_reg)
        begin
            clr_cnt_reg <= clr_cnt_reg + RW'(1);
            if (clr_cnt_reg == LAST_ROW)
            begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    // lane j holds word byte (j - off) mod 4; lanes below the offset sit one row up
    always_comb
    begin
        logic [1:0] k;
        for (int j = 0; j < 4; j++)
        begin
            k = 2'(j) - off;
            if (clr_busy_reg)
            begin
                rows[j]   = clr_cnt_reg;
                wbytes[j] = '0;
            end
            else
            begin
                rows[j]   = row_base + RW'(2'(j) < off);
                wbytes[j] = req.wdata[{k, 3'b000} +: 8];
            end
        end
    end

    for (genvar j = 0; j < 4; j++)
    begin : g_lane
        logic [7:0] bank [ROWS];
        logic [7:0] q_reg;

        always_ff @(posedge clk)
        begin
            if (wen)
            begin
                bank[rows[j]] <= wbytes[j];
            end
            if (req.rd)
            begin
                q_reg <= bank[rows[j]];
            end
        end

        assign lane_q[j] = q_reg;
    end

    always_ff @(posedge clk)
    begin
        if (req.rd)
        begin
            off_reg <= off;
        end
    end

    always_comb
    begin
        logic [1:0] sel;
        for (int k = 0; k < 4; k++)
        begin
            sel = off_reg + 2'(k);
            rdata[8*k +: 8] = lane_q[sel];
        end
    end

endmodule

### sv/rvsx_exec.sv
// Instruction decode, ALU, branch target and memory address check for one item.
module rvsx_exec
    import rvsx_pkg::*;
#(
    parameter int MEM_BYTES = 65536
)
(
    input  logic            kind,
    input  logic [XLEN-1:0] instr,
    input  logic [15:0]     load_address,
    input  logic [XLEN-1:0] load_data,
    input  logic [XLEN-1:0] rs1_val,
    input  logic [XLEN-1:0] rs2_val,
    input  logic [XLEN-1:0] pc,
    input  logic            halted,
    output exec_res_t       res
);

    localparam logic [33:0] WORD_LIMIT = 34'(MEM_BYTES - 4);

    logic [6:0]      op;
    logic [6:0]      f7;
    logic [2:0]      f3;
    logic [4:0]      rd;
    logic [XLEN-1:0] imm_i;
    logic [XLEN-1:0] imm_s;
    logic [XLEN-1:0] imm_b;
    logic [XLEN-1:0] imm_j;
    logic [XLEN-1:0] mem_imm;
    logic [33:0]     ea;
    logic            ea_bad;
    logic            pl_bad;

    assign op = instr[6:0];
    assign rd = instr[11:7];
    assign f3 = instr[14:12];
    assign f7 = instr[31:25];

    assign imm_i = {{20{instr[31]}}, instr[31:20]};
    assign imm_s = {{20{instr[31]}}, instr[31:25], instr[11:7]};
    assign imm_b = {{19{instr[31]}}, instr[31], instr[7], instr[30:25], instr[11:8], 1'b0};
    assign imm_j = {{11{instr[31]}}, instr[31], instr[19:12], instr[20], instr[30:21], 1'b0};

    // effective address without wrap: bit 33 flags a negative sum
    assign mem_imm = (op == OP_STORE) ? imm_s : imm_i;
    assign ea      = {2'b00, rs1_val} + {{2{mem_imm[31]}}, mem_imm};
    assign ea_bad  = ea[33] || (ea > WORD_LIMIT);
    assign pl_bad  = {18'b0, load_address} > WORD_LIMIT;

    always_comb
    begin
        logic [XLEN-1:0] npc;
        logic [XLEN-1:0] wval;
        logic            dowr;
        status_t         st;

        npc  = pc + XLEN'(4);
        wval = '0;
        dowr = 1'b0;
        st   = ST_OK;
        res  = '0;
        res.next_pc = pc;
        res.status  = ST_OK;

        if (kind == ITEM_PRELOAD)
        begin
            res.status    = pl_bad ? ST_VIOLATION : ST_OK;
            res.mem.wr    = !pl_bad;
            res.mem.addr  = {16'b0, load_address};
            res.mem.wdata = load_data;
        end
        else if (halted)
        begin
            res.status = ST_HALTED;
        end
        else
        begin
            unique case (op)
                OP_REG:
                begin
                    if (f3 == F3_ADD && f7 == F7_ADD)
                    begin
                        dowr = 1'b1;
                        wval = rs1_val + rs2_val;
                    end
                    else if (f3 == F3_ADD && f7 == F7_SUB)
                    begin
                        dowr = 1'b1;
                        wval = rs1_val - rs2_val;
                    end
                end
                OP_IMM:
                begin
                    if (f3 == F3_ADD)
                    begin
                        dowr = 1'b1;
                        wval = rs1_val + imm_i;
                    end
                end
                OP_LOAD:
                begin
                    if (f3 == F3_WORD)
                    begin
                        if (ea_bad)
                        begin
                            st = ST_VIOLATION;
                        end
                        else
                        begin
                            dowr = 1'b1;
                            res.mem.rd = 1'b1;
                        end
                    end
                end
                OP_STORE:
                begin
                    if (f3 == F3_WORD)
                    begin
                        if (ea_bad)
                        begin
                            st = ST_VIOLATION;
                        end
                        else
                        begin
                            res.mem.wr    = 1'b1;
                            res.mem.wdata = rs2_val;
                        end
                    end
                end
                OP_BRANCH:
                begin
                    if (f3 == F3_BEQ && rs1_val == rs2_val)
                    begin
                        npc = pc + imm_b;
                    end
                end
                OP_JAL:
                begin
                    dowr = 1'b1;
                    wval = pc + XLEN'(4);
                    npc  = pc + imm_j;
                end
                OP_SYSTEM:
                begin
                    if (instr == ECALL_WORD)
                    begin
                        st = ST_ECALL;
                    end
                end
                default:
                begin
                    st = ST_UNKNOWN;
                end
            endcase

            res.mem.addr = ea[XLEN-1:0];
            res.status   = st;
            if (st != ST_OK)
            begin
                res.halt = 1'b1;
            end
            else
            begin
                res.next_pc = npc;
                if (dowr && rd != REG_ZERO)
                begin
                    res.reg_we    = 1'b1;
                    res.reg_idx   = rd;
                    res.reg_value = wval;
                end
            end
        end
    end

endmodule

### sv/rv32i_subset_executor.sv
// Each item is held in the execute stage and its result is registered at the output when it retires;
// lw first waits there for the synchronous read port of the data memory. Throughput: one item per
// cycle while the output register is free and no lw holds the execute stage.
// Reset: after rst_n the data memory is swept to zero, one row of four bytes per cycle,
// with s_axis_tready low until the sweep ends; registers come up via valid bits.
module rv32i_subset_executor
    import rvsx_pkg::*;
#(
    parameter int MEM_BYTES = 65536
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,  // instr[31:0], load_address[47:32], load_data[79:48]
    input  logic        s_axis_tuser,  // item kind, 0 for execute and 1 for preload
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata   // status[2:0], next_pc[34:3], reg_written[35],
                                       // reg_index[40:36], reg_value[72:41], zero[79:73]
);

    logic            x_valid_reg;
    logic            x_phase_reg;
    logic            x_kind_reg;
    logic [XLEN-1:0] x_instr_reg;
    logic [15:0]     x_laddr_reg;
    logic [XLEN-1:0] x_ldata_reg;
    logic [XLEN-1:0] pc_reg;
    logic            halted_reg;
    logic            m_valid_reg;
    logic [79:0]     m_data_reg;

    logic            accept;
    logic            out_free;
    logic            load_pending;
    logic            retire;
    logic            mem_busy;
    logic [XLEN-1:0] rs1_val;
    logic [XLEN-1:0] rs2_val;
    logic [XLEN-1:0] dmem_rdata;
    logic [XLEN-1:0] wb_value;
    exec_res_t       res;
    mem_req_t        mem_req;
    rf_write_t       rf_wr;

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;
    assign load_pending  = res.mem.rd && !x_phase_reg;
    assign retire        = x_valid_reg && !load_pending && out_free;
    assign s_axis_tready = !mem_busy && (!x_valid_reg || retire);

    rvsx_exec #(
        .MEM_BYTES (MEM_BYTES)
    ) u_exec (
        .kind         (x_kind_reg),
        .instr        (x_instr_reg),
        .load_address (x_laddr_reg),
        .load_data    (x_ldata_reg),
        .rs1_val      (rs1_val),
        .rs2_val      (rs2_val),
        .pc           (pc_reg),
        .halted       (halted_reg),
        .res          (res)
    );

    assign wb_value = res.mem.rd ? dmem_rdata : res.reg_value;

    always_comb
    begin
        rf_wr.en   = retire && res.reg_we;
        rf_wr.idx  = res.reg_idx;
        rf_wr.data = wb_value;
    end

    rvsx_regfile #(
        .MEM_BYTES (MEM_BYTES)
    ) u_regfile (
        .clk   (clk),
        .rst_n (rst_n),
        .rd_en (accept),
        .ra1   (s_axis_tdata[19:15]),
        .ra2   (s_axis_tdata[24:20]),
        .wr    (rf_wr),
        .rd1   (rs1_val),
        .rd2   (rs2_val)
    );

    always_comb
    begin
        mem_req       = res.mem;
        mem_req.rd    = x_valid_reg && load_pending;
        mem_req.wr    = retire && res.mem.wr;
    end

    rvsx_dmem #(
        .MEM_BYTES (MEM_BYTES)
    ) u_dmem (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mem_req),
        .rdata (dmem_rdata),
        .busy  (mem_busy)
    );

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_kind_reg  <= s_axis_tuser;
            x_instr_reg <= s_axis_tdata[31:0];
            x_laddr_reg <= s_axis_tdata[47:32];
            x_ldata_reg <= s_axis_tdata[79:48];
        end
        if (retire)
        begin
            m_data_reg <= {7'b0, wb_value & {XLEN{res.reg_we}}, res.reg_idx, res.reg_we,
                           res.next_pc, res.status};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_valid_reg <= 1'b0;
            x_phase_reg <= 1'b0;
            pc_reg      <= '0;
            halted_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                x_valid_reg <= 1'b1;
            end
            else if (retire)
            begin
                x_valid_reg <= 1'b0;
            end

            if (accept || retire)
            begin
                x_phase_reg <= 1'b0;
            end
            else if (x_valid_reg && load_pending)
            begin
                x_phase_reg <= 1'b1;
            end

            if (retire)
            begin
                pc_reg      <= res.next_pc;
                halted_reg  <= halted_reg || res.halt;
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    a_no_item_during_clear: assert property (@(posedge clk) disable iff (!rst_n)
        mem_busy |-> !x_valid_reg)
        else $error("item in execute stage during memory clear");

    a_phase_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        x_phase_reg |-> x_valid_reg)
        else $error("load phase set with empty execute stage");

    a_load_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (retire && res.mem.rd) |-> x_phase_reg)
        else $error("load retired before its memory read");

    a_halt_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |=> halted_reg)
        else $error("halt flag cleared");

    a_no_x0_write: assert property (@(posedge clk) disable iff (!rst_n)
        rf_wr.en |-> (rf_wr.idx != REG_ZERO))
        else $error("write to x0");

endmodule
